// ----- hw/rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// Software timer table package
// Sizes, command and result codes, slot record and sequencer states shared by
// the timer table modules.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int RESULT_CAP = 16;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int RES_W      = $clog2(RESULT_CAP + 1);
  localparam int RM_W       = 5;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 72;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_ADDED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] count;
    logic        once;
    logic [31:0] tag;
    logic [31:0] arg;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    slot_t            data;
  } slot_wr_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        due;
    logic        tag_hit;
  } alu_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Clamp a removal count to the width of the result field
  function automatic logic [RM_W-1:0] sat_removed(input logic [CNT_W-1:0] v);
    logic [RM_W-1:0] r;
    if (int'(v) > (2 ** RM_W) - 1) begin
      r = '1;
    end else begin
      r = RM_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/stt_alu.sv -----
// ----------------------------------------------------------------------------
// Timer slot arithmetic unit
// Saturating count update, expiry compare and tag match for one slot; shared
// by every step of a tick or clear walk.
// ----------------------------------------------------------------------------
module stt_alu (
  input  logic [31:0]      count,
  input  logic [31:0]      delta,
  input  logic [31:0]      period,
  input  logic [31:0]      slot_tag,
  input  logic [31:0]      match_tag,
  output stt_pkg::alu_res_t res
);
  import stt_pkg::*;

  logic [32:0] wide_sum;
  logic [31:0] sat_sum;

  assign wide_sum = {1'b0, count} + {1'b0, delta};
  assign sat_sum  = wide_sum[32] ? 32'hFFFF_FFFF : wide_sum[31:0];

  assign res.sum     = sat_sum;
  assign res.due     = (sat_sum >= period);
  // a zero clear tag never matches
  assign res.tag_hit = (match_tag != 32'd0) && (slot_tag == match_tag);

endmodule

// ----- hw/rtl/stt_table.sv -----
// ----------------------------------------------------------------------------
// Timer slot register file
// Holds the timer records; one read port addressed by the walk pointer and
// one write port.
// ----------------------------------------------------------------------------
module stt_table (
  input  logic                            clk,
  input  logic [stt_pkg::IDX_W-1:0]       rd_idx,
  output stt_pkg::slot_t                  rd_data,
  input  stt_pkg::slot_wr_t               wr
);
  import stt_pkg::*;

  slot_t slots [MAX_TIMERS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      slots[wr.idx] <= wr.data;
    end
  end

  assign rd_data = slots[rd_idx];

endmodule

// ----- hw/rtl/software_timer_table.sv -----
// ----------------------------------------------------------------------------
// Software timer table
// Ordered table of software timers with add, tick and clear-by-tag commands.
// ----------------------------------------------------------------------------
// An add is written in the add state unless the table is full, and its
// result is loaded once the result register is free. A tick or a clear
// walks the stored timers one slot per cycle, while no fired result waits
// on a held result register, through a single saturating adder and
// comparator, compacting the table in place, and then ends in a flush step.
// Fired timers come out in table order; tlast marks the final result of a
// command. The input is not ready until the current command has finished.
module software_timer_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // period[31:0], tag[63:32], handler_arg[95:64], one_shot[96],
  // delta[128:97], zero fill above
  input  logic [stt_pkg::IN_DATA_W-1:0]      s_tdata,
  // command[1:0]
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // fired_tag[31:0], fired_arg[63:32], removed_count[68:64], zero fill above
  output logic [stt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // kind[1:0]
  output logic [1:0]                         m_tuser,
  output logic                               m_tlast
);
  import stt_pkg::*;

  state_t state, state_next;

  // latched command
  logic [1:0]  cmd;
  logic [31:0] cmd_period;
  logic [31:0] cmd_tag;
  logic [31:0] cmd_arg;
  logic        cmd_once;
  logic [31:0] cmd_delta;

  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic [RES_W-1:0] fired_n;
  logic [CNT_W-1:0] removed;

  // last fired result, held until the next one shows it was not the final one
  logic        pend_valid;
  logic [31:0] pend_tag;
  logic [31:0] pend_arg;

  logic [31:0]     out_tag;
  logic [31:0]     out_arg;
  logic [RM_W-1:0] out_removed;
  logic [1:0]      out_kind;
  logic            out_last;

  slot_t     cur;
  slot_wr_t  wr;
  alu_res_t  alu;

  logic            accept;
  logic            out_free;
  logic            walk_done;
  logic            is_tick;
  logic            emit;
  logic            drop;
  logic            step;
  logic            full;
  logic            load_out;
  logic [1:0]      load_kind;
  logic [31:0]     load_tag;
  logic [31:0]     load_arg;
  logic [RM_W-1:0] load_removed;
  logic            load_last;

  stt_table u_table (
    .clk     (clk),
    .rd_idx  (rd_ptr[IDX_W-1:0]),
    .rd_data (cur),
    .wr      (wr)
  );

  stt_alu u_alu (
    .count     (cur.count),
    .delta     (cmd_delta),
    .period    (cur.period),
    .slot_tag  (cur.tag),
    .match_tag (cmd_tag),
    .res       (alu)
  );

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign walk_done = (rd_ptr == used);
  assign is_tick   = (cmd == CMD_TICK);
  assign full      = (used == CNT_W'(MAX_TIMERS));
  assign emit      = is_tick && alu.due && (cur.tag != 32'd0) &&
                     (fired_n < RES_W'(RESULT_CAP));
  assign drop      = is_tick ? (alu.due && cur.once) : alu.tag_hit;

  always_comb begin
    state_next   = state;
    step         = 1'b0;
    wr           = '0;
    load_out     = 1'b0;
    load_kind    = KIND_FIRED;
    load_tag     = 32'd0;
    load_arg     = 32'd0;
    load_removed = '0;
    load_last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (s_tuser)
            CMD_ADD:   state_next = ST_ADD;
            CMD_TICK:  state_next = ST_WALK;
            CMD_CLEAR: state_next = ST_WALK;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          state_next = ST_IDLE;
          if (full) begin
            load_kind = KIND_FULL;
          end else begin
            load_kind        = KIND_ADDED;
            wr.en            = 1'b1;
            wr.idx           = used[IDX_W-1:0];
            wr.data.period   = cmd_period;
            wr.data.count    = 32'd0;
            wr.data.once     = cmd_once;
            wr.data.tag      = cmd_tag;
            wr.data.arg      = cmd_arg;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_FLUSH;
        end else if (!(emit && pend_valid && !out_free)) begin
          step = 1'b1;
          // compact: keep survivors packed at the write pointer
          if (!drop) begin
            wr.en   = 1'b1;
            wr.idx  = wr_ptr[IDX_W-1:0];
            wr.data = cur;
            if (is_tick) begin
              wr.data.count = alu.due ? 32'd0 : alu.sum;
            end
          end
          if (emit && pend_valid) begin
            load_out  = 1'b1;
            load_kind = KIND_FIRED;
            load_tag  = pend_tag;
            load_arg  = pend_arg;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (is_tick) begin
            load_out  = pend_valid;
            load_kind = KIND_FIRED;
            load_tag  = pend_tag;
            load_arg  = pend_arg;
            load_last = 1'b1;
          end else begin
            load_out     = 1'b1;
            load_kind    = KIND_CLEAR;
            load_removed = sat_removed(removed);
            load_last    = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_ADD && out_free && !full) begin
        used <= used + CNT_W'(1);
      end
      if (state == ST_WALK && walk_done) begin
        used <= wr_ptr;
      end
      if (accept) begin
        pend_valid <= 1'b0;
      end else if (step && emit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= s_tuser;
      cmd_period <= s_tdata[31:0];
      cmd_tag    <= s_tdata[63:32];
      cmd_arg    <= s_tdata[95:64];
      cmd_once   <= s_tdata[96];
      cmd_delta  <= s_tdata[128:97];
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fired_n    <= '0;
      removed    <= '0;
    end else if (step) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
      if (!drop) begin
        wr_ptr <= wr_ptr + CNT_W'(1);
      end else if (!is_tick) begin
        removed <= removed + CNT_W'(1);
      end
      if (emit) begin
        fired_n  <= fired_n + RES_W'(1);
        pend_tag <= cur.tag;
        pend_arg <= cur.arg;
      end
    end
    if (load_out) begin
      out_kind    <= load_kind;
      out_tag     <= load_tag;
      out_arg     <= load_arg;
      out_removed <= load_removed;
      out_last    <= load_last;
    end
  end

  assign m_tdata = {(OUT_DATA_W - 64 - RM_W)'(0), out_removed, out_arg, out_tag};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule
